// File: sv/msf_pkg.sv
// Package for the multi-stack shared free list block.
// Holds field widths, parameter defaults, request and status codes and the
// controller state type. No dependencies.
package msf_pkg;

   // Parameter defaults.
   localparam int NUM_STACKS_DEF = 4;
   localparam int NUM_SLOTS_DEF  = 16;

   // Field widths of the request and the response.
   localparam int CMD_W        = 1;
   localparam int STACK_ID_W   = 2;
   localparam int VALUE_W      = 32;
   localparam int STATUS_W     = 2;
   localparam int MAX_IDS      = 1 << STACK_ID_W;

   // Stream widths: stack_id and push_value padded to whole bytes.
   localparam int REQ_TDATA_W  = ((STACK_ID_W + VALUE_W + 7) / 8) * 8;
   localparam int REQ_TUSER_W  = CMD_W;
   localparam int RSP_TDATA_W  = VALUE_W;
   localparam int RSP_TUSER_W  = STATUS_W;

   // Operation codes.
   localparam logic [CMD_W-1:0] CMD_PUSH = 1'b0;
   localparam logic [CMD_W-1:0] CMD_POP  = 1'b1;

   // Status codes.
   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

endpackage

// File: sv/msf_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Read data holds while no read is enabled. No dependencies.
module msf_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/multi_stack_shared_free_list.sv
// Flow: an accepted request reads the link and value memories into their registered read
// ports and moves to the execute state; its response is registered when that state ends,
// and a stalled response holds the execute state until the response register frees.
// The block takes no new request until it is back in the idle state, so requests do not
// overlap.
// Reset: synchronous; clears stack tops to null, free head to slot 0 and the fill count.
// The link memory is never cleared: slots at or above the fill count read as linked to
// the next slot.
module multi_stack_shared_free_list #(
   parameter int NUM_STACKS = msf_pkg::NUM_STACKS_DEF,
   parameter int NUM_SLOTS  = msf_pkg::NUM_SLOTS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // [1:0] stack_id, [33:2] push_value, upper bits zero
   input  logic [msf_pkg::REQ_TDATA_W-1:0]  req_tdata,
   // [0] cmd
   input  logic [msf_pkg::REQ_TUSER_W-1:0]  req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // [31:0] pop_value
   output logic [msf_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   // [1:0] status
   output logic [msf_pkg::RSP_TUSER_W-1:0]  rsp_tuser
);
   import msf_pkg::*;

   // Slot addresses, and links that also encode null as NUM_SLOTS.
   localparam int AW  = $clog2(NUM_SLOTS);
   localparam int LW  = $clog2(NUM_SLOTS + 1);
   // Only the stacks that a stack_id can name need a top register.
   localparam int TD  = (NUM_STACKS < MAX_IDS) ? NUM_STACKS : MAX_IDS;
   localparam int TIW = (TD > 1) ? $clog2(TD) : 1;
   localparam logic [LW-1:0] LINK_NULL = LW'(NUM_SLOTS);

   state_type state_ff, state_in;

   // Request held through the execute cycle.
   logic [CMD_W-1:0]   cmd_ff,      cmd_in;
   logic [TIW-1:0]     idx_ff,      idx_in;
   logic [VALUE_W-1:0] val_ff,      val_in;
   logic [LW-1:0]      slot_ff,     slot_in;
   logic               ok_ff,       ok_in;
   logic [LW-1:0]      old_top_ff,  old_top_in;

   // Stack tops, free-list head and the count of slots ever allocated.
   logic [LW-1:0]      top_ff [TD];
   logic [LW-1:0]      top_in [TD];
   logic [LW-1:0]      free_head_ff, free_head_in;
   logic [LW-1:0]      fill_ff,      fill_in;

   // Response register.
   logic                rsp_valid_ff,  rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [VALUE_W-1:0]  rsp_value_ff,  rsp_value_in;

   // Memory ports.
   logic               rd_en;
   logic [AW-1:0]      rd_addr;
   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   logic [LW-1:0]      link_wr_data;
   logic [LW-1:0]      link_rd_data;
   logic [VALUE_W-1:0] value_rd_data;

   // Decode of the incoming request.
   logic [CMD_W-1:0]      req_cmd;
   logic [STACK_ID_W-1:0] req_id;
   logic                  req_id_ok;
   logic [LW-1:0]         req_top;
   logic                  accept;
   logic                  done;
   logic [LW-1:0]         next_link;

   assign req_cmd   = req_tuser[CMD_W-1:0];
   assign req_id    = req_tdata[STACK_ID_W-1:0];
   assign req_id_ok = (32'(req_id) < 32'(NUM_STACKS));
   assign req_top   = req_id_ok ? top_ff[req_id[TIW-1:0]] : LINK_NULL;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   // The execute cycle finishes once the response register can take the result.
   assign done       = (state_ff == ST_EXEC) && (!rsp_valid_ff || rsp_tready);

   // A slot at or above the fill count has never been allocated, so its link
   // is still the initial chain to the next slot (null after the last one).
   assign next_link = (slot_ff >= fill_ff) ? (slot_ff + LW'(1)) : link_rd_data;

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      idx_in        = idx_ff;
      val_in        = val_ff;
      slot_in       = slot_ff;
      ok_in         = ok_ff;
      old_top_in    = old_top_ff;
      top_in        = top_ff;
      free_head_in  = free_head_ff;
      fill_in       = fill_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      rd_en         = 1'b0;
      rd_addr       = '0;
      wr_en         = 1'b0;
      wr_addr       = slot_ff[AW-1:0];
      link_wr_data  = old_top_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd_in     = req_cmd;
               idx_in     = req_id[TIW-1:0];
               val_in     = req_tdata[STACK_ID_W +: VALUE_W];
               old_top_in = req_top;
               if (req_cmd == CMD_PUSH) begin
                  slot_in = free_head_ff;
                  ok_in   = req_id_ok && (free_head_ff < LINK_NULL);
               end else begin
                  slot_in = req_top;
                  ok_in   = (req_top < LINK_NULL);
               end
               rd_en    = ok_in;
               rd_addr  = slot_in[AW-1:0];
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (done) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = '0;
               rsp_status_in = (cmd_ff == CMD_PUSH) ? STATUS_FULL : STATUS_EMPTY;
               if (ok_ff) begin
                  rsp_status_in = STATUS_OK;
                  wr_en         = 1'b1;
                  if (cmd_ff == CMD_PUSH) begin
                     // Take the free head, link it above the old top.
                     free_head_in   = next_link;
                     link_wr_data   = old_top_ff;
                     top_in[idx_ff] = slot_ff;
                     if (slot_ff == fill_ff) begin
                        fill_in = fill_ff + LW'(1);
                     end
                  end else begin
                     // Unlink the top and return its slot to the free list.
                     top_in[idx_ff] = next_link;
                     link_wr_data   = free_head_ff;
                     free_head_in   = slot_ff;
                     rsp_value_in   = value_rd_data;
                  end
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         free_head_ff <= '0;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < TD; i++) begin
            top_ff[i] <= LINK_NULL;
         end
      end else begin
         state_ff     <= state_in;
         free_head_ff <= free_head_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
         top_ff       <= top_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      idx_ff        <= idx_in;
      val_ff        <= val_in;
      slot_ff       <= slot_in;
      ok_ff         <= ok_in;
      old_top_ff    <= old_top_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
   end

   // Links below each slot; written on every successful request.
   msf_ram #(
      .WIDTH (LW),
      .DEPTH (NUM_SLOTS)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (link_wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (link_rd_data)
   );

   // Slot values; written only by a push.
   msf_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (NUM_SLOTS)
   ) u_value_ram (
      .clock   (clock),
      .wr_en   (wr_en && (cmd_ff == CMD_PUSH)),
      .wr_addr (wr_addr),
      .wr_data (val_ff),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (value_rd_data)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_value_ff;
   assign rsp_tuser  = rsp_status_ff;

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for multi_stack_shared_free_list: push and pop
// requests go in on the request stream, and each status and popped value is
// checked against a predictor. Depends on msf_pkg and the block's top level.
module tb_top;
   import msf_pkg::*;

   // The store geometry follows the block's parameter defaults. A link of
   // SLOT_COUNT means "no slot", both in the free list and in the stack tops.
   localparam int SLOT_COUNT  = NUM_SLOTS_DEF;
   localparam int STACK_COUNT = NUM_STACKS_DEF;
   localparam int SLOT_W      = $clog2(SLOT_COUNT);
   localparam int LINK_W      = SLOT_W + 1;
   localparam logic [LINK_W-1:0] NO_SLOT = LINK_W'(SLOT_COUNT);

   localparam int RANDOM_ITEMS    = 900;
   localparam int LONG_HOLD_AFTER = 300;     // accepted requests before the long stall
   localparam int LONG_HOLD_LEN   = 200;     // cycles the receiver holds off
   localparam int TAIL_CYCLES     = 10;
   localparam int CYCLE_LIMIT     = 200000;
   localparam int MAX_PRINTED     = 100;

   // One expected response: the status code and the popped value.
   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [VALUE_W-1:0]  value;
   } stack_reply_type;

   // One row of the directed table. A row may repeat its request; a repeated
   // push adds the repeat index to the value so every slot gets its own data.
   // Where use_typed is set the response is typed in here, otherwise the
   // predictor supplies it.
   typedef struct packed {
      logic [CMD_W-1:0]      cmd;
      logic [STACK_ID_W-1:0] sid;
      logic [VALUE_W-1:0]    value;
      logic [4:0]            reps;
      logic                  use_typed;
      logic [STATUS_W-1:0]   exp_status;
      logic [VALUE_W-1:0]    exp_value;
   } directed_row_type;

   // Directed part: popping an empty stack, the signed extremes going through
   // two stacks in LIFO order, then one stack filling the whole store so that
   // a push to another stack finds the store full, and an empty pop while the
   // store is full.
   localparam directed_row_type DIRECTED_ROWS [0:9] = '{
      '{CMD_POP,  2'd0, 32'h0000_0000, 5'd1,  1'b1, STATUS_EMPTY, 32'h0000_0000},
      '{CMD_PUSH, 2'd0, 32'h8000_0000, 5'd1,  1'b1, STATUS_OK,    32'h0000_0000},
      '{CMD_PUSH, 2'd1, 32'h7FFF_FFFF, 5'd1,  1'b1, STATUS_OK,    32'h0000_0000},
      '{CMD_POP,  2'd1, 32'hFFFF_FFFF, 5'd1,  1'b1, STATUS_OK,    32'h7FFF_FFFF},
      '{CMD_POP,  2'd0, 32'h0000_0000, 5'd1,  1'b1, STATUS_OK,    32'h8000_0000},
      '{CMD_POP,  2'd0, 32'h0000_0000, 5'd1,  1'b1, STATUS_EMPTY, 32'h0000_0000},
      '{CMD_PUSH, 2'd3, 32'hA5A5_0000, 5'd16, 1'b0, STATUS_OK,    32'h0000_0000},
      '{CMD_PUSH, 2'd2, 32'hFFFF_FFFF, 5'd1,  1'b1, STATUS_FULL,  32'h0000_0000},
      '{CMD_POP,  2'd2, 32'h0000_0000, 5'd1,  1'b1, STATUS_EMPTY, 32'h0000_0000},
      '{CMD_POP,  2'd3, 32'h5A5A_5A5A, 5'd1,  1'b0, STATUS_OK,    32'h0000_0000}
   };

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   // [1:0] stack_id, [33:2] push_value, upper bits zero
   logic [REQ_TDATA_W-1:0] req_tdata;
   // [0] cmd
   logic [REQ_TUSER_W-1:0] req_tuser;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   // [31:0] pop_value
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   // [1:0] status
   logic [RSP_TUSER_W-1:0] rsp_tuser;

   // Predictor state: a copy of the slot store, its links, the stack tops and
   // the head of the free list.
   logic [VALUE_W-1:0] slot_data [SLOT_COUNT];
   logic [LINK_W-1:0]  slot_next [SLOT_COUNT];
   logic [LINK_W-1:0]  top_slot  [STACK_COUNT];
   logic [LINK_W-1:0]  free_slot;

   stack_reply_type pending_replies [$];
   int              mismatch_count;
   int              accepted_count;
   int              burst_left;
   int              cycle_count;

   multi_stack_shared_free_list u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Applies one request to the predictor state and returns the response the
   // block must give. A link or top at or beyond SLOT_COUNT counts as no slot.
   function automatic stack_reply_type apply_stack_op(input logic [CMD_W-1:0] cmd,
                                                      input logic [STACK_ID_W-1:0] sid,
                                                      input logic [VALUE_W-1:0] value);
      stack_reply_type   reply;
      logic [SLOT_W-1:0] slot;
      reply.status = STATUS_OK;
      reply.value  = '0;
      if (cmd == CMD_PUSH) begin
         if (int'(sid) >= STACK_COUNT || free_slot >= NO_SLOT) begin
            reply.status = STATUS_FULL;
         end else begin
            slot                 = free_slot[SLOT_W-1:0];
            free_slot            = slot_next[slot];
            slot_data[slot]      = value;
            slot_next[slot]      = top_slot[sid];
            top_slot[sid]        = {1'b0, slot};
         end
      end else begin
         if (int'(sid) >= STACK_COUNT || top_slot[sid] >= NO_SLOT) begin
            reply.status = STATUS_EMPTY;
         end else begin
            slot            = top_slot[sid][SLOT_W-1:0];
            top_slot[sid]   = slot_next[slot];
            slot_next[slot] = free_slot;
            free_slot       = {1'b0, slot};
            reply.value     = slot_data[slot];
         end
      end
      return reply;
   endfunction

   // Prints one line per mismatch and counts it. Printing stops after a
   // while so that a badly broken block does not flood the log, but every
   // mismatch is still counted.
   task automatic report_mismatch(input string what);
      if (mismatch_count < MAX_PRINTED) begin
         $display("ERROR at cycle %0d: %s", cycle_count, what);
      end
      mismatch_count++;
   endtask

   // Offers one request on the request stream and waits until it is taken.
   // The sender works in bursts; between bursts it drops tvalid for a random
   // number of cycles. Once the request is accepted the predictor runs, and
   // either its answer or the typed-in answer joins the queue of pending
   // replies.
   task automatic offer_request(input logic [CMD_W-1:0] cmd,
                                input logic [STACK_ID_W-1:0] sid,
                                input logic [VALUE_W-1:0] value,
                                input bit use_typed,
                                input stack_reply_type typed);
      stack_reply_type predicted;
      int              gap;
      if (burst_left == 0) begin
         gap = $urandom_range(1, 8);
         repeat (gap) begin
            @(negedge clock);
            req_tvalid <= 1'b0;
         end
         // Now and then a long burst gives a stretch with no sender idling.
         burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 150)
                                                  : $urandom_range(1, 20);
      end
      burst_left--;
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {{(REQ_TDATA_W - VALUE_W - STACK_ID_W){1'b0}}, value, sid};
      do @(posedge clock); while (req_tready !== 1'b1);
      predicted = apply_stack_op(cmd, sid, value);
      pending_replies.push_back(use_typed ? typed : predicted);
      accepted_count++;
   endtask

   // Response checker: every response accepted at a rising edge is compared
   // with the oldest pending reply, status first, then the popped value.
   initial begin
      stack_reply_type want;
      forever begin
         @(posedge clock);
         if (rsp_tvalid === 1'b1 && rsp_tready === 1'b1) begin
            if (pending_replies.size() == 0) begin
               report_mismatch($sformatf("response with no request pending: status %0d value %h",
                                         rsp_tuser, rsp_tdata));
            end else begin
               want = pending_replies.pop_front();
               if (rsp_tuser !== want.status) begin
                  report_mismatch($sformatf("status %0d, expected %0d", rsp_tuser, want.status));
               end
               if (rsp_tdata !== want.value) begin
                  report_mismatch($sformatf("pop value %h, expected %h", rsp_tdata, want.value));
               end
            end
         end
      end
   end

   // Receiver: stalls on a pattern of its own. Now and then it picks at random
   // among always ready, ready half the time and ready a quarter
   // of the time. Once enough requests have been accepted it holds off for a
   // long stretch, so that the response register fills and the block has to
   // stall its request side while the sender keeps offering.
   initial begin
      int  hold_left;
      int  mode;
      int  mode_left;
      bit  long_hold_done;
      logic ready_next;
      hold_left      = 0;
      mode           = 0;
      mode_left      = 0;
      long_hold_done = 1'b0;
      rsp_tready     = 1'b0;
      forever begin
         @(negedge clock);
         if (!long_hold_done && accepted_count >= LONG_HOLD_AFTER) begin
            long_hold_done = 1'b1;
            hold_left      = LONG_HOLD_LEN;
         end
         if (mode_left == 0) begin
            mode      = $urandom_range(0, 2);
            mode_left = $urandom_range(32, 96);
         end
         mode_left--;
         if (hold_left > 0) begin
            hold_left--;
            ready_next = 1'b0;
         end else begin
            case (mode)
               0: ready_next = 1'b1;
               1: ready_next = 1'($urandom_range(0, 1));
               default: ready_next = ($urandom_range(0, 3) == 0);
            endcase
         end
         rsp_tready <= ready_next;
      end
   end

   // Watchdog: counts cycles and gives up far beyond the slowest correct run.
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Simulation FAILED");
      $finish;
   end

   // Main sequence: reset, directed table, random traffic, drain, verdict.
   initial begin
      stack_reply_type typed;
      int              row;
      int              rep;
      int              item;
      int              push_pct;
      int              phase_left;
      bit              focused;
      logic [STACK_ID_W-1:0] focus_sid;
      logic [CMD_W-1:0]      cmd;
      logic [STACK_ID_W-1:0] sid;
      logic [VALUE_W-1:0]    value;

      reset          = 1'b1;
      req_tvalid     = 1'b0;
      req_tdata      = '0;
      req_tuser      = '0;
      mismatch_count = 0;
      accepted_count = 0;
      burst_left     = 0;
      phase_left     = 0;
      push_pct       = 50;
      focused        = 1'b0;
      focus_sid      = '0;

      // The predictor starts from the reset state: every slot chained into
      // the free list in order, all stacks empty.
      for (int i = 0; i < SLOT_COUNT; i++) begin
         slot_data[i] = '0;
         slot_next[i] = LINK_W'(i + 1);
      end
      for (int i = 0; i < STACK_COUNT; i++) begin
         top_slot[i] = NO_SLOT;
      end
      free_slot = '0;

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (row = 0; row < $size(DIRECTED_ROWS); row++) begin
         typed.status = DIRECTED_ROWS[row].exp_status;
         typed.value  = DIRECTED_ROWS[row].exp_value;
         for (rep = 0; rep < int'(DIRECTED_ROWS[row].reps); rep++) begin
            offer_request(DIRECTED_ROWS[row].cmd, DIRECTED_ROWS[row].sid,
                          DIRECTED_ROWS[row].value + VALUE_W'(rep),
                          DIRECTED_ROWS[row].use_typed, typed);
         end
      end

      // The sender pauses here until the directed part has fully drained.
      @(negedge clock);
      req_tvalid <= 1'b0;
      wait (pending_replies.size() == 0);

      // Random traffic runs in phases. Each phase leans toward pushes, pops
      // or neither, so the store repeatedly fills to the point where pushes
      // fail and drains until pops find stacks empty. Some phases work one
      // stack mostly, which builds deep chains through the link store.
      typed = '0;
      for (item = 0; item < RANDOM_ITEMS; item++) begin
         if (phase_left == 0) begin
            case ($urandom_range(0, 2))
               0: push_pct = 85;
               1: push_pct = 50;
               default: push_pct = 15;
            endcase
            phase_left = $urandom_range(40, 80);
            focused    = $urandom_range(0, 2) == 0;
            focus_sid  = STACK_ID_W'($urandom_range(0, MAX_IDS - 1));
         end
         phase_left--;

         cmd = ($urandom_range(0, 99) < push_pct) ? CMD_PUSH : CMD_POP;
         if (focused && $urandom_range(0, 9) < 7) begin
            sid = focus_sid;
         end else begin
            sid = STACK_ID_W'($urandom_range(0, MAX_IDS - 1));
         end
         // Signed extremes, zero and minus one show up often enough to be
         // popped back out; pops carry random data that must be ignored.
         case ($urandom_range(0, 7))
            0: value = 32'h8000_0000;
            1: value = 32'h7FFF_FFFF;
            2: value = 32'hFFFF_FFFF;
            3: value = 32'h0000_0000;
            default: value = $urandom;
         endcase

         // Halfway through, the sender once more waits for every response.
         if (item == RANDOM_ITEMS / 2) begin
            @(negedge clock);
            req_tvalid <= 1'b0;
            wait (pending_replies.size() == 0);
         end
         offer_request(cmd, sid, value, 1'b0, typed);
      end

      @(negedge clock);
      req_tvalid <= 1'b0;
      wait (pending_replies.size() == 0);
      // The tail wait catches any response the block sends unasked.
      repeat (TAIL_CYCLES) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
